// ----- rtl/modinv_pkg.sv -----
// Package for the modular inverse block.
// Holds the sequencer state type and the field width defaults; no dependencies.
package modinv_pkg;

    localparam int FIELD_BITS = 64;
    localparam int WORD_BITS_DEFAULT = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_MOD,
        ST_FINISH
    } state_t;

endpackage

// ----- rtl/modular_inverse_ext_euclid.sv -----
// Modular inverse by the extended Euclidean algorithm, top level.
// Depends on modinv_pkg for the state type and width defaults.
//
// A beat is taken when start is high and busy is low. Each Euclid step runs one
// shared restoring divider, one quotient bit per cycle, and builds q * s on the fly
// by shift and add. After the last step the same divider reduces the coefficient
// modulo the modulus, and a finish state forms the inverse. The number of Euclid
// iterations can reach about 93 at 64 bits; a zero modulus skips the divider and goes
// straight to the finish state. The result appears on the result ports with done high
// for a single cycle; the receiver cannot stall, so it must capture the beat in that
// cycle. Bits of value and modulus above WORD_BITS are ignored.
module modular_inverse_ext_euclid
    import modinv_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FIELD_BITS-1:0] value,
    input  logic [FIELD_BITS-1:0] modulus,
    output logic                  busy,
    output logic                  done,
    output logic [FIELD_BITS-1:0] inverse,
    output logic [FIELD_BITS-1:0] gcd,
    output logic                  not_invertible,
    output logic                  modulus_zero
);

    localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

    state_t state_reg, state_next;

    logic [WORD_BITS-1:0] r_prev_reg, r_prev_next;
    logic [WORD_BITS-1:0] r_cur_reg, r_cur_next;
    logic [WORD_BITS-1:0] s_prev_reg, s_prev_next;
    logic [WORD_BITS-1:0] s_cur_reg, s_cur_next;
    logic [WORD_BITS-1:0] m_reg, m_next;
    logic [WORD_BITS-1:0] dq_reg, dq_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] p_reg, p_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 odd_reg, odd_next;
    logic                 mzero_reg, mzero_next;

    logic                  done_reg, done_next;
    logic [FIELD_BITS-1:0] inverse_reg, inverse_next;
    logic [FIELD_BITS-1:0] gcd_reg, gcd_next;
    logic                  not_inv_reg, not_inv_next;
    logic                  mz_out_reg, mz_out_next;

    logic [WORD_BITS-1:0] x_in;
    logic [WORD_BITS-1:0] m_in;
    logic                 accept;
    logic [WORD_BITS-1:0] divisor;
    logic [WORD_BITS:0]   rem_sh;
    logic [WORD_BITS:0]   diff;
    logic                 qbit;
    logic [WORD_BITS-1:0] rem_step;
    logic [WORD_BITS-1:0] p_step;
    logic [WORD_BITS-1:0] mag;
    logic [WORD_BITS-1:0] inv_word;
    logic [FIELD_BITS-1:0] inv_ext;
    logic [FIELD_BITS-1:0] gcd_ext;

    assign x_in   = value[WORD_BITS-1:0];
    assign m_in   = modulus[WORD_BITS-1:0];
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // shared restoring divide step
    assign divisor  = (state_reg == ST_MOD) ? m_reg : r_cur_reg;
    assign rem_sh   = {rem_reg, dq_reg[WORD_BITS-1]};
    assign diff     = rem_sh - {1'b0, divisor};
    assign qbit     = !diff[WORD_BITS];
    assign rem_step = qbit ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
    assign p_step   = {p_reg[WORD_BITS-2:0], 1'b0} + (qbit ? s_cur_reg : '0);

    assign mag      = rem_reg;
    assign inv_word = (odd_reg && (mag != '0)) ? (m_reg - mag) : mag;

    always_comb
    begin
        inv_ext = '0;
        gcd_ext = '0;
        inv_ext[WORD_BITS-1:0] = inv_word;
        gcd_ext[WORD_BITS-1:0] = r_prev_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (m_in == '0) ? ST_FINISH : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = (rem_reg == '0) ? ST_MOD : ST_DIV;
            end
            ST_MOD:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        r_prev_next  = r_prev_reg;
        r_cur_next   = r_cur_reg;
        s_prev_next  = s_prev_reg;
        s_cur_next   = s_cur_reg;
        m_next       = m_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        p_next       = p_reg;
        cnt_next     = cnt_reg;
        odd_next     = odd_reg;
        mzero_next   = mzero_reg;
        done_next    = 1'b0;
        inverse_next = inverse_reg;
        gcd_next     = gcd_reg;
        not_inv_next = not_inv_reg;
        mz_out_next  = mz_out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    r_prev_next = x_in;
                    r_cur_next  = m_in;
                    s_prev_next = WORD_BITS'(1);
                    s_cur_next  = '0;
                    m_next      = m_in;
                    dq_next     = x_in;
                    rem_next    = '0;
                    p_next      = '0;
                    cnt_next    = '0;
                    odd_next    = 1'b0;
                    mzero_next  = (m_in == '0);
                end
            end
            ST_DIV:
            begin
                dq_next  = {dq_reg[WORD_BITS-2:0], qbit};
                rem_next = rem_step;
                p_next   = p_step;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_STEP:
            begin
                r_prev_next = r_cur_reg;
                r_cur_next  = rem_reg;
                s_prev_next = s_cur_reg;
                s_cur_next  = s_prev_reg + p_reg;
                odd_next    = !odd_reg;
                dq_next     = (rem_reg == '0) ? s_cur_reg : r_cur_reg;
                rem_next    = '0;
                p_next      = '0;
                cnt_next    = '0;
            end
            ST_MOD:
            begin
                dq_next  = {dq_reg[WORD_BITS-2:0], qbit};
                rem_next = rem_step;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_FINISH:
            begin
                done_next = 1'b1;
                if (mzero_reg)
                begin
                    inverse_next = '0;
                    gcd_next     = '0;
                    not_inv_next = 1'b0;
                    mz_out_next  = 1'b1;
                end
                else
                begin
                    inverse_next = inv_ext;
                    gcd_next     = gcd_ext;
                    not_inv_next = (r_prev_reg != WORD_BITS'(1));
                    mz_out_next  = 1'b0;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            odd_reg   <= 1'b0;
            mzero_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            odd_reg   <= odd_next;
            mzero_reg <= mzero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_prev_reg  <= r_prev_next;
        r_cur_reg   <= r_cur_next;
        s_prev_reg  <= s_prev_next;
        s_cur_reg   <= s_cur_next;
        m_reg       <= m_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        p_reg       <= p_next;
        inverse_reg <= inverse_next;
        gcd_reg     <= gcd_next;
        not_inv_reg <= not_inv_next;
        mz_out_reg  <= mz_out_next;
    end

    assign done           = done_reg;
    assign inverse        = inverse_reg;
    assign gcd            = gcd_reg;
    assign not_invertible = not_inv_reg;
    assign modulus_zero   = mz_out_reg;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for modular_inverse_ext_euclid.
// Uses modinv_pkg for FIELD_BITS. Typed directed rows give their expected results; the
// rest and random pairs are checked against an in-bench extended Euclid inverse calculation.
module testbench;
    import modinv_pkg::*;

    localparam int WORD_BITS    = 64;
    localparam int RANDOM_ITEMS = 268;
    localparam int TAIL_CYCLES  = 200;

    typedef struct packed {
        logic [FIELD_BITS-1:0] inverse;
        logic [FIELD_BITS-1:0] gcd;
        logic                  not_invertible;
        logic                  modulus_zero;
    } inv_result_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] value;
        logic [FIELD_BITS-1:0] modulus;
        logic                  typed;
        inv_result_t           result;
    } stim_row_t;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FIB_92   = 64'd7540113804746346429;
    localparam logic [63:0] FIB_93   = 64'd12200160415121876738;
    localparam logic [63:0] PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam int          DIRECTED_ROWS = 23;

    logic                  clk;
    logic                  rst_n   = 1'b0;
    logic                  start   = 1'b0;
    logic [FIELD_BITS-1:0] value   = '0;
    logic [FIELD_BITS-1:0] modulus = '0;
    logic                  busy;
    logic                  done;
    logic [FIELD_BITS-1:0] inverse;
    logic [FIELD_BITS-1:0] gcd;
    logic                  not_invertible;
    logic                  modulus_zero;

    inv_result_t pending_inverses[$];
    int          error_count = 0;
    int          no_gap_left = 0;
    stim_row_t   directed_rows [DIRECTED_ROWS];

    modular_inverse_ext_euclid #(
        .WORD_BITS(WORD_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .value         (value),
        .modulus       (modulus),
        .busy          (busy),
        .done          (done),
        .inverse       (inverse),
        .gcd           (gcd),
        .not_invertible(not_invertible),
        .modulus_zero  (modulus_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic inv_result_t euclid_inverse(input logic [63:0] v_in,
                                                   input logic [63:0] m_in);
        logic [63:0] word_mask;
        logic [63:0] x, m, r_prev, r_cur, s_prev, s_cur, q, nr, ns, mag;
        bit          odd_steps;
        inv_result_t res;
        word_mask = (WORD_BITS >= 64) ? ALL_ONES : ((64'd1 << WORD_BITS) - 64'd1);
        x = v_in & word_mask;
        m = m_in & word_mask;
        res = '0;
        if (m == 0)
        begin
            res.modulus_zero = 1'b1;
            return res;
        end
        r_prev = x;
        r_cur = m;
        s_prev = 64'd1;
        s_cur = 64'd0;
        odd_steps = 1'b0;
        while (r_cur != 0)
        begin
            q = r_prev / r_cur;
            nr = r_prev - q * r_cur;
            ns = s_prev + q * s_cur;
            r_prev = r_cur;
            r_cur = nr;
            s_prev = s_cur;
            s_cur = ns;
            odd_steps = ~odd_steps;
        end
        mag = s_prev % m;
        res.inverse = (odd_steps && mag != 0) ? (m - mag) & word_mask : mag & word_mask;
        res.gcd = r_prev & word_mask;
        res.not_invertible = (r_prev != 64'd1);
        return res;
    endfunction

    function automatic logic [63:0] rand_word(input int unsigned nbits);
        logic [63:0] w;
        w = {$urandom, $urandom};
        if (nbits < 64)
            w = w & ((64'd1 << nbits) - 64'd1);
        return w;
    endfunction

    // drive one beat, hold it until taken, then idle as drawn
    task automatic send_item(input logic [63:0] v, input logic [63:0] m,
                             input logic typed, input inv_result_t typed_result);
        int unsigned gap;
        bit          wait_idle;
        value <= v;
        modulus <= m;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_inverses.push_back(typed ? typed_result : euclid_inverse(v, m));
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            return;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            no_gap_left = $urandom_range(4, 12);
            return;
        end
        gap = $urandom_range(0, 12);
        wait_idle = ($urandom_range(0, 1) == 1);
        if (gap == 0 && !wait_idle)
            return;
        start <= 1'b0;
        value <= {$urandom, $urandom};
        modulus <= {$urandom, $urandom};
        if (wait_idle)
        begin
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
        repeat (gap) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_inverses.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual inverse %h gcd %h",
                         $time, inverse, gcd);
                error_count++;
            end
            else
            begin
                inv_result_t want;
                want = pending_inverses.pop_front();
                if (inverse !== want.inverse)
                begin
                    $display("%0t: inverse mismatch: expected %h, actual %h",
                             $time, want.inverse, inverse);
                    error_count++;
                end
                if (gcd !== want.gcd)
                begin
                    $display("%0t: gcd mismatch: expected %h, actual %h",
                             $time, want.gcd, gcd);
                    error_count++;
                end
                if (not_invertible !== want.not_invertible)
                begin
                    $display("%0t: not_invertible mismatch: expected %b, actual %b",
                             $time, want.not_invertible, not_invertible);
                    error_count++;
                end
                if (modulus_zero !== want.modulus_zero)
                begin
                    $display("%0t: modulus_zero mismatch: expected %b, actual %b",
                             $time, want.modulus_zero, modulus_zero);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        logic [63:0] v, m, g;
        directed_rows = '{
            '{64'd0,            64'd0,            1'b1, '{64'd0,            64'd0,    1'b0, 1'b1}},
            '{ALL_ONES,         64'd0,            1'b1, '{64'd0,            64'd0,    1'b0, 1'b1}},
            '{64'd0,            64'd1,            1'b1, '{64'd0,            64'd1,    1'b0, 1'b0}},
            '{ALL_ONES,         64'd1,            1'b1, '{64'd0,            64'd1,    1'b0, 1'b0}},
            '{64'd0,            ALL_ONES,         1'b1, '{64'd0,            ALL_ONES, 1'b1, 1'b0}},
            '{64'd0,            64'd97,           1'b1, '{64'd0,            64'd97,   1'b1, 1'b0}},
            '{64'd1,            ALL_ONES,         1'b1, '{64'd1,            64'd1,    1'b0, 1'b0}},
            '{ALL_ONES,         ALL_ONES,         1'b1, '{64'd0,            ALL_ONES, 1'b1, 1'b0}},
            '{ALL_ONES - 64'd1, ALL_ONES,         1'b1, '{ALL_ONES - 64'd1, 64'd1,    1'b0, 1'b0}},
            '{64'd1,            64'd2,            1'b1, '{64'd1,            64'd1,    1'b0, 1'b0}},
            '{64'd3,            64'd7,            1'b1, '{64'd5,            64'd1,    1'b0, 1'b0}},
            '{64'd10,           64'd7,            1'b0, '0},
            '{64'd6,            64'd9,            1'b0, '0},
            '{FIB_92,           FIB_93,           1'b0, '0},
            '{FIB_93,           FIB_92,           1'b0, '0},
            '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
            '{ALL_ONES,         64'h8000_0000_0000_0000, 1'b0, '0},
            '{64'd2,            64'h8000_0000_0000_0000, 1'b0, '0},
            '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB, 1'b0, '0},
            '{64'd12345,        64'd2,            1'b0, '0},
            '{64'd2,            ALL_ONES,         1'b0, '0},
            '{PRIME_64,         64'd3,            1'b0, '0},
            '{64'd3,            PRIME_64,         1'b0, '0}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].value, directed_rows[i].modulus,
                      directed_rows[i].typed, directed_rows[i].result);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    v = rand_word($urandom_range(0, 64));
                    m = 64'd0;
                end
                1:
                begin
                    v = rand_word($urandom_range(0, 64));
                    m = 64'd1;
                end
                2:
                begin
                    v = 64'd0;
                    m = rand_word($urandom_range(1, 64));
                end
                3, 4, 5:
                begin
                    g = rand_word(16);
                    if (g < 2)
                        g = 64'd2;
                    v = g * rand_word($urandom_range(0, 44));
                    m = g * rand_word($urandom_range(1, 44));
                end
                6, 7, 8, 9:
                begin
                    v = rand_word($urandom_range(1, 16));
                    m = rand_word($urandom_range(1, 16));
                end
                default:
                begin
                    v = rand_word($urandom_range(1, 64));
                    m = rand_word($urandom_range(1, 64));
                end
            endcase
            send_item(v, m, 1'b0, '0);
        end

        if (start)
            start <= 1'b0;
        while (pending_inverses.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
